FILE: design/mtte_pkg.sv
`default_nettype none

package mtte_pkg;

  localparam int unsigned MAX_TEXT_LEN_DEF = 64;
  localparam logic [15:0] TAP_TIMEOUT_RST  = 16'd800;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  localparam logic [3:0] KEY_DIGIT_LAST = 4'd9;
  localparam logic [3:0] KEY_MODE       = 4'd10;
  localparam logic [3:0] KEY_BACK       = 4'd11;
  localparam logic [3:0] KEY_LEFT       = 4'd12;
  localparam logic [3:0] KEY_RIGHT      = 4'd13;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_LOWER   = 2'd0,
    MODE_UPPER   = 2'd1,
    MODE_NUMERIC = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_FIN
  } state_e;

  // number of characters behind a digit key
  function automatic logic [2:0] map_len(input logic [3:0] key);
    logic [2:0] n;
    case (key)
      4'd0: n = 3'd2;
      4'd1, 4'd7, 4'd9: n = 3'd5;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // character for a digit key at a tap position
  function automatic logic [7:0] cand_char(input logic [3:0] key, input logic [2:0] tap,
                                           input logic upper);
    logic [7:0] ch;
    logic [7:0] base;
    logic [2:0] nlet;
    ch   = CHAR_ZERO + {4'h0, key};
    base = 8'h00;
    nlet = 3'd0;
    case (key)
      4'd0: begin
        ch = (tap == 3'd0) ? CHAR_SPACE : CHAR_ZERO;
      end
      4'd1: begin
        case (tap)
          3'd0: ch = 8'h2E;
          3'd1: ch = 8'h2C;
          3'd2: ch = 8'h21;
          3'd3: ch = 8'h3F;
          default: ch = 8'h31;
        endcase
      end
      default: begin
        case (key)
          4'd2: begin base = 8'h61; nlet = 3'd3; end
          4'd3: begin base = 8'h64; nlet = 3'd3; end
          4'd4: begin base = 8'h67; nlet = 3'd3; end
          4'd5: begin base = 8'h6A; nlet = 3'd3; end
          4'd6: begin base = 8'h6D; nlet = 3'd3; end
          4'd7: begin base = 8'h70; nlet = 3'd4; end
          4'd8: begin base = 8'h74; nlet = 3'd3; end
          4'd9: begin base = 8'h77; nlet = 3'd4; end
          default: begin base = 8'h00; nlet = 3'd0; end
        endcase
        if (tap < nlet) begin
          ch = base + {5'h00, tap};
          if (upper) begin
            ch = ch - CASE_SHIFT;
          end
        end
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: design/mtte_text_mem.sv
`default_nettype none

module mtte_text_mem
  import mtte_pkg::*;
#(
  parameter int unsigned Depth = MAX_TEXT_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/mtte_ctrl.sv
`default_nettype none

module mtte_ctrl
  import mtte_pkg::*;
#(
  parameter int unsigned MaxTextLen = MAX_TEXT_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [3:0]                    key_code_i,
  input  wire logic [5:0]                    read_index_i,
  input  wire logic [15:0]                   timeout_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic      [7:0]                    read_char_o,
  output logic      [6:0]                    cursor_out_o,
  output logic      [6:0]                    length_out_o,
  output logic      [1:0]                    mode_out_o,
  output logic                               pending_out_o,
  output logic                               mem_we_o,
  output logic      [$clog2(MaxTextLen)-1:0] mem_waddr_o,
  output logic      [7:0]                    mem_wdata_o,
  output logic                               mem_re_o,
  output logic      [$clog2(MaxTextLen)-1:0] mem_raddr_o,
  input  wire logic [7:0]                    mem_rdata_i
);

  localparam int unsigned AddrW = $clog2(MaxTextLen);
  localparam int unsigned LenW  = $clog2(MaxTextLen + 1);
  localparam int unsigned CmpW  = (LenW > 6) ? LenW : 6;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxTextLen);

  state_e            state_q, state_d;
  logic [LenW-1:0]   cursor_q, cursor_d;
  logic [LenW-1:0]   length_q, length_d;
  mode_e             mode_q, mode_d;
  logic [3:0]        last_key_q, last_key_d;
  logic [2:0]        tap_q, tap_d;
  logic [15:0]       ticks_q, ticks_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic [7:0]        rchar_q, rchar_d;
  logic              hit_q, hit_d;
  logic              is_ins_q, is_ins_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic              wr_vld_q, wr_vld_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [7:0]        char_q, char_d;

  logic              accept;
  logic [LenW-1:0]   c1;
  logic [LenW-1:0]   l1;
  logic              ins_ok;
  logic              upper;
  logic [2:0]        tap_nx;
  logic [15:0]       tick_nx;
  logic              is_digit;
  logic              same_key;
  logic              go_ins;
  logic              go_rem;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign c1       = (pend_q && (cursor_q < MaxLen)) ? cursor_q + LenW'(1) : cursor_q;
  assign l1       = (c1 > length_q) ? c1 : length_q;
  assign ins_ok   = l1 < MaxLen;
  assign upper    = (mode_q == MODE_UPPER);
  assign tap_nx   = ((tap_q + 3'd1) == map_len(key_code_i)) ? 3'd0 : tap_q + 3'd1;
  assign tick_nx  = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + 16'd1;
  assign is_digit = key_code_i <= KEY_DIGIT_LAST;
  assign same_key = pend_q && (key_code_i == last_key_q);

  // request decode: which requests need the shift engine
  always_comb begin
    go_ins = 1'b0;
    go_rem = 1'b0;
    if (accept && (operation_i == OP_KEY)) begin
      case (key_code_i)
        KEY_BACK: begin
          go_rem = pend_q ? (cursor_q < length_q) : (cursor_q != '0);
        end
        KEY_MODE, KEY_LEFT, KEY_RIGHT: begin
          go_ins = 1'b0;
        end
        default: begin
          if (is_digit) begin
            go_ins = ins_ok && ((mode_q == MODE_NUMERIC) || !same_key);
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_READ)) begin
          state_d = ST_READ;
        end else if (go_ins || go_rem) begin
          state_d = ST_SHIFT;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SHIFT: begin
        if (cnt_q == '0) begin
          state_d = is_ins_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and memory port
  always_comb begin
    cursor_d    = cursor_q;
    length_d    = length_q;
    mode_d      = mode_q;
    last_key_d  = last_key_q;
    tap_d       = tap_q;
    ticks_d     = ticks_q;
    pend_d      = pend_q;
    done_d      = 1'b0;
    rchar_d     = rchar_q;
    hit_d       = hit_q;
    is_ins_d    = is_ins_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    wr_vld_d    = wr_vld_q;
    wr_addr_d   = wr_addr_q;
    pos_d       = pos_q;
    char_d      = char_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rchar_d  = '0;
          wr_vld_d = 1'b0;
          done_d   = !(go_ins || go_rem || (operation_i == OP_READ));
          case (operation_i)
            OP_KEY: begin
              case (key_code_i)
                KEY_MODE: begin
                  cursor_d = c1;
                  length_d = l1;
                  pend_d   = 1'b0;
                  tap_d    = '0;
                  case (mode_q)
                    MODE_LOWER: mode_d = MODE_UPPER;
                    MODE_UPPER: mode_d = MODE_NUMERIC;
                    default:    mode_d = MODE_LOWER;
                  endcase
                end
                KEY_BACK: begin
                  if (pend_q) begin
                    pend_d = 1'b0;
                    tap_d  = '0;
                    if (go_rem) begin
                      length_d = length_q - LenW'(1);
                      is_ins_d = 1'b0;
                      cnt_d    = length_q - LenW'(1) - cursor_q;
                      rd_ptr_d = AddrW'(cursor_q + LenW'(1));
                    end
                  end else if (go_rem) begin
                    cursor_d = cursor_q - LenW'(1);
                    length_d = length_q - LenW'(1);
                    is_ins_d = 1'b0;
                    cnt_d    = length_q - cursor_q;
                    rd_ptr_d = AddrW'(cursor_q);
                  end
                end
                KEY_LEFT: begin
                  pend_d   = 1'b0;
                  tap_d    = '0;
                  length_d = l1;
                  cursor_d = (c1 != '0) ? c1 - LenW'(1) : c1;
                end
                KEY_RIGHT: begin
                  pend_d   = 1'b0;
                  tap_d    = '0;
                  length_d = l1;
                  cursor_d = (c1 < l1) ? c1 + LenW'(1) : c1;
                end
                default: begin
                  if (is_digit) begin
                    if ((mode_q != MODE_NUMERIC) && same_key) begin
                      tap_d       = tap_nx;
                      ticks_d     = '0;
                      mem_we_o    = 1'b1;
                      mem_waddr_o = AddrW'(cursor_q);
                      mem_wdata_o = cand_char(key_code_i, tap_nx, upper);
                    end else begin
                      pend_d   = 1'b0;
                      tap_d    = '0;
                      cursor_d = c1;
                      length_d = l1;
                      if (ins_ok) begin
                        length_d = l1 + LenW'(1);
                        is_ins_d = 1'b1;
                        cnt_d    = l1 - c1;
                        rd_ptr_d = AddrW'(l1 - LenW'(1));
                        pos_d    = AddrW'(c1);
                        if (mode_q == MODE_NUMERIC) begin
                          cursor_d = c1 + LenW'(1);
                          char_d   = CHAR_ZERO + {4'h0, key_code_i};
                        end else begin
                          char_d     = cand_char(key_code_i, 3'd0, upper);
                          last_key_d = key_code_i;
                          ticks_d    = '0;
                          pend_d     = 1'b1;
                        end
                      end
                    end
                  end
                end
              endcase
            end
            OP_TICK: begin
              if (pend_q) begin
                ticks_d = tick_nx;
                if (tick_nx >= timeout_i) begin
                  cursor_d = c1;
                  length_d = l1;
                  pend_d   = 1'b0;
                  tap_d    = '0;
                end
              end
            end
            OP_READ: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrW'(read_index_i);
              hit_d       = CmpW'(read_index_i) < CmpW'(length_q);
            end
            default: begin
              rchar_d = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        rchar_d = hit_q ? mem_rdata_i : 8'h00;
        done_d  = 1'b1;
      end
      ST_SHIFT: begin
        if (wr_vld_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (cnt_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_ptr_q;
          wr_vld_d    = 1'b1;
          cnt_d       = cnt_q - LenW'(1);
          wr_addr_d   = is_ins_q ? rd_ptr_q + AddrW'(1) : rd_ptr_q - AddrW'(1);
          rd_ptr_d    = is_ins_q ? rd_ptr_q - AddrW'(1) : rd_ptr_q + AddrW'(1);
        end else begin
          wr_vld_d = 1'b0;
          done_d   = !is_ins_q;
        end
      end
      ST_FIN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = char_q;
        done_d      = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cursor_q   <= '0;
      length_q   <= '0;
      mode_q     <= MODE_LOWER;
      last_key_q <= '0;
      tap_q      <= '0;
      ticks_q    <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
      rchar_q    <= '0;
      hit_q      <= 1'b0;
      is_ins_q   <= 1'b0;
      cnt_q      <= '0;
      wr_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      length_q   <= length_d;
      mode_q     <= mode_d;
      last_key_q <= last_key_d;
      tap_q      <= tap_d;
      ticks_q    <= ticks_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
      rchar_q    <= rchar_d;
      hit_q      <= hit_d;
      is_ins_q   <= is_ins_d;
      cnt_q      <= cnt_d;
      wr_vld_q   <= wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    wr_addr_q <= wr_addr_d;
    pos_q     <= pos_d;
    char_q    <= char_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign read_char_o   = rchar_q;
  assign cursor_out_o  = 7'(cursor_q);
  assign length_out_o  = 7'(length_q);
  assign mode_out_o    = mode_q;
  assign pending_out_o = pend_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= MaxLen)
    else $error("text length beyond store size");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && (cursor_q < length_q)) || (!pend_q && (cursor_q <= length_q)))
    else $error("cursor outside text");

  a_no_cand_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (mode_q != MODE_NUMERIC))
    else $error("candidate pending in numeric mode");

  a_char_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (rchar_q != 8'h00)) |-> $past(state_q == ST_READ))
    else $error("character returned without a store read");
`endif

endmodule

`default_nettype wire

FILE: design/multi_tap_text_entry_unit.sv
`default_nettype none

// keypad multi-tap text editor
// request channel: start_i with operation_i, key_code_i and read_index_i is taken at a
// clock edge where busy_o is low. one result per request, shown on the result ports for
// a single cycle with done_o high; the receiver cannot stall, so results must be taken
// when they appear. a new request may be taken in the cycle its predecessor's result
// is shown.
// ticks, cursor moves, mode changes, repeat taps and ignored codes give their result in
// the cycle after the request; a store read goes through ST_READ, which registers the
// store output as the result. an insert or delete shifts the text store one entry per
// cycle through the memory's single write port.
// one request is in work at a time; busy_o is high until its result is shown.
// tap_timeout_we_i/tap_timeout_wdata_i write the tap timeout; the user must do so only
// while idle, as the block itself does not enforce it.
// reset: text empty, cursor 0, lowercase mode, nothing pending, timeout 800 ticks.
// the store needs no clearing pass: entries at or beyond the length are never returned.

module multi_tap_text_entry_unit
  import mtte_pkg::*;
#(
  parameter int unsigned MaxTextLen = MAX_TEXT_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [3:0]  key_code_i,
  input  wire logic [5:0]  read_index_i,
  input  wire logic        tap_timeout_we_i,
  input  wire logic [15:0] tap_timeout_wdata_i,
  output logic             done_o,
  output logic      [7:0]  read_char_o,
  output logic      [6:0]  cursor_out_o,
  output logic      [6:0]  length_out_o,
  output logic      [1:0]  mode_out_o,
  output logic             pending_out_o
);

  localparam int unsigned AddrW = $clog2(MaxTextLen);

  logic [15:0]      timeout_q, timeout_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  assign timeout_d = tap_timeout_we_i ? tap_timeout_wdata_i : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TAP_TIMEOUT_RST;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  mtte_ctrl #(
    .MaxTextLen(MaxTextLen)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .operation_i  (operation_i),
    .key_code_i   (key_code_i),
    .read_index_i (read_index_i),
    .timeout_i    (timeout_q),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .read_char_o  (read_char_o),
    .cursor_out_o (cursor_out_o),
    .length_out_o (length_out_o),
    .mode_out_o   (mode_out_o),
    .pending_out_o(pending_out_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  mtte_text_mem #(
    .Depth(MaxTextLen)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_multi_tap_text_entry_unit.sv
`timescale 1ns / 100ps

module tb_multi_tap_text_entry_unit;
  import mtte_pkg::*;

  localparam int MAX_LEN     = MAX_TEXT_LEN_DEF;
  localparam int CYCLE_LIMIT = 1_200_000;

  localparam logic [3:0] KEY_SPARE_LO = 4'd14;
  localparam logic [3:0] KEY_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [7:0] ch;
    logic [6:0] cur;
    logic [6:0] len;
    logic [1:0] mode;
    logic       pend;
  } view_t;

  typedef struct {
    op_e        op;
    logic [3:0] key;
    logic [5:0] idx;
    bit         typed;
    view_t      view;
  } request_t;

  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        start_i             = 1'b0;
  logic [1:0]  operation_i         = OP_NOP;
  logic [3:0]  key_code_i          = 4'd0;
  logic [5:0]  read_index_i        = 6'd0;
  logic        tap_timeout_we_i    = 1'b0;
  logic [15:0] tap_timeout_wdata_i = 16'd0;
  logic        busy_o;
  logic        done_o;
  logic [7:0]  read_char_o;
  logic [6:0]  cursor_out_o;
  logic [6:0]  length_out_o;
  logic [1:0]  mode_out_o;
  logic        pending_out_o;

  // typed expectation travelling with the request
  bit    view_typed = 1'b0;
  view_t view_fixed = '0;

  always #10 clk_i = ~clk_i;

  multi_tap_text_entry_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .operation_i        (operation_i),
    .key_code_i         (key_code_i),
    .read_index_i       (read_index_i),
    .tap_timeout_we_i   (tap_timeout_we_i),
    .tap_timeout_wdata_i(tap_timeout_wdata_i),
    .done_o             (done_o),
    .read_char_o        (read_char_o),
    .cursor_out_o       (cursor_out_o),
    .length_out_o       (length_out_o),
    .mode_out_o         (mode_out_o),
    .pending_out_o      (pending_out_o)
  );

  // editor state as the block should hold it
  logic [7:0]  text_mem [MAX_LEN];
  logic [6:0]  cur_pos;
  logic [6:0]  text_len;
  mode_e       mode_now;
  logic [3:0]  cand_key;
  logic [2:0]  tap_idx;
  logic [15:0] idle_ticks;
  logic        cand_live;
  logic [15:0] timeout_reg;

  view_t editor_view_q [$];
  int    mismatches = 0;
  int    live_items = 0;
  int    burst_left = 0;
  bit    steady     = 1'b0;

  function automatic string key_letters(input logic [3:0] key);
    case (key)
      4'd0: return " 0";
      4'd1: return ".,!?1";
      4'd2: return "abc2";
      4'd3: return "def3";
      4'd4: return "ghi4";
      4'd5: return "jkl5";
      4'd6: return "mno6";
      4'd7: return "pqrs7";
      4'd8: return "tuv8";
      default: return "wxyz9";
    endcase
  endfunction

  function automatic logic [7:0] glyph_for(input logic [3:0] key, input logic [2:0] tap);
    string      seq;
    logic [7:0] ch;
    seq = key_letters(key);
    ch  = seq[tap % seq.len()];
    if (mode_now == MODE_UPPER && ch >= "a" && ch <= "z") begin
      ch = ch - 8'h20;
    end
    return ch;
  endfunction

  function automatic void editor_reset();
    for (int i = 0; i < MAX_LEN; i++) begin
      text_mem[i] = 8'h00;
    end
    cur_pos     = '0;
    text_len    = '0;
    mode_now    = MODE_LOWER;
    cand_key    = '0;
    tap_idx     = '0;
    idle_ticks  = '0;
    cand_live   = 1'b0;
    timeout_reg = TAP_TIMEOUT_RST;
  endfunction

  function automatic void commit_glyph();
    if (!cand_live) begin
      return;
    end
    cand_live = 1'b0;
    tap_idx   = '0;
    if (cur_pos < MAX_LEN) begin
      cur_pos++;
      if (cur_pos > text_len) begin
        text_len = cur_pos;
      end
    end
  endfunction

  function automatic bit insert_glyph(input logic [7:0] ch);
    if (text_len >= MAX_LEN || cur_pos > text_len) begin
      return 1'b0;
    end
    for (int i = text_len; i > cur_pos; i--) begin
      text_mem[i] = text_mem[i-1];
    end
    text_mem[cur_pos] = ch;
    text_len++;
    return 1'b1;
  endfunction

  function automatic void erase_at(input logic [6:0] pos);
    if (pos >= text_len) begin
      return;
    end
    for (int i = pos; i + 1 < text_len; i++) begin
      text_mem[i] = text_mem[i+1];
    end
    text_len--;
    text_mem[text_len] = 8'h00;
  endfunction

  function automatic void press_key(input logic [3:0] key);
    string seq;
    if (key == KEY_MODE) begin
      commit_glyph();
      case (mode_now)
        MODE_LOWER: mode_now = MODE_UPPER;
        MODE_UPPER: mode_now = MODE_NUMERIC;
        default:    mode_now = MODE_LOWER;
      endcase
    end else if (key == KEY_BACK) begin
      if (cand_live) begin
        cand_live = 1'b0;
        tap_idx   = '0;
        erase_at(cur_pos);
      end else if (cur_pos > 0) begin
        erase_at(cur_pos - 7'd1);
        cur_pos--;
      end
    end else if (key == KEY_LEFT) begin
      commit_glyph();
      if (cur_pos > 0) begin
        cur_pos--;
      end
    end else if (key == KEY_RIGHT) begin
      commit_glyph();
      if (cur_pos < text_len) begin
        cur_pos++;
      end
    end else if (key <= KEY_DIGIT_LAST) begin
      if (mode_now == MODE_NUMERIC) begin
        commit_glyph();
        if (insert_glyph(CHAR_ZERO + {4'h0, key})) begin
          cur_pos++;
        end
      end else if (cand_live && key == cand_key) begin
        seq     = key_letters(key);
        tap_idx = 3'((tap_idx + 1) % seq.len());
        if (cur_pos < MAX_LEN) begin
          text_mem[cur_pos] = glyph_for(key, tap_idx);
        end
        idle_ticks = '0;
      end else begin
        commit_glyph();
        if (insert_glyph(glyph_for(key, 3'd0))) begin
          cand_key   = key;
          tap_idx    = '0;
          idle_ticks = '0;
          cand_live  = 1'b1;
        end
      end
    end
  endfunction

  function automatic view_t editor_apply(input op_e op, input logic [3:0] key,
                                         input logic [5:0] idx);
    view_t v;
    v.ch = 8'h00;
    case (op)
      OP_KEY: press_key(key);
      OP_TICK: begin
        if (cand_live) begin
          if (idle_ticks < TICKS_MAX) begin
            idle_ticks++;
          end
          if (idle_ticks >= timeout_reg) begin
            commit_glyph();
          end
        end
      end
      OP_READ: begin
        if (idx < text_len) begin
          v.ch = text_mem[idx];
        end
      end
      default: ;
    endcase
    v.cur  = cur_pos;
    v.len  = text_len;
    v.mode = mode_now;
    v.pend = cand_live;
    return v;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    view_t seen;
    view_t want;
    if (!rst_ni) begin
      editor_reset();
    end else begin
      if (done_o) begin
        seen = {read_char_o, cursor_out_o, length_out_o, mode_out_o, pending_out_o};
        if (editor_view_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual ch=%02h cur=%0d len=%0d",
                   $time, seen.ch, seen.cur, seen.len, " mode=%0d pend=%0d",
                   seen.mode, seen.pend);
          mismatches++;
        end else begin
          want = editor_view_q.pop_front();
          if (seen !== want) begin
            $display("%0t mismatch: expected ch=%02h cur=%0d len=%0d mode=%0d pend=%0d,",
                     $time, want.ch, want.cur, want.len, want.mode, want.pend,
                     " actual ch=%02h cur=%0d len=%0d mode=%0d pend=%0d",
                     seen.ch, seen.cur, seen.len, seen.mode, seen.pend);
            mismatches++;
          end
        end
      end
      if (tap_timeout_we_i) begin
        timeout_reg = tap_timeout_wdata_i;
      end
      if (start_i && !busy_o) begin
        want = editor_apply(op_e'(operation_i), key_code_i, read_index_i);
        editor_view_q.push_back(view_typed ? view_fixed : want);
      end
    end
  end

  function automatic logic [3:0] rand_key();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [5:0] rand_idx();
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic request_t mk(input op_e op, input logic [3:0] key, input logic [5:0] idx);
    request_t r;
    r.op    = op;
    r.key   = key;
    r.idx   = idx;
    r.typed = 1'b0;
    r.view  = '0;
    return r;
  endfunction

  function automatic request_t mk_t(input op_e op, input logic [3:0] key, input logic [5:0] idx,
                                    input logic [7:0] ch, input logic [6:0] cur,
                                    input logic [6:0] len, input mode_e m, input logic pend);
    request_t r;
    r = mk(op, key, idx);
    r.typed     = 1'b1;
    r.view.ch   = ch;
    r.view.cur  = cur;
    r.view.len  = len;
    r.view.mode = m;
    r.view.pend = pend;
    return r;
  endfunction

  task automatic send_item(input request_t r);
    operation_i  <= r.op;
    key_code_i   <= r.key;
    read_index_i <= r.idx;
    view_typed   <= r.typed;
    view_fixed   <= r.view;
    start_i      <= 1'b1;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    if (!(r.op == OP_NOP || (r.op == OP_KEY && r.key > KEY_RIGHT))) begin
      live_items++;
    end
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        start_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(9, 70)) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
      end
    end
  endtask

  task automatic send_plain(input op_e op, input logic [3:0] key, input logic [5:0] idx);
    send_item(mk(op, key, idx));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (editor_view_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_timeout(input logic [15:0] value);
    start_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    tap_timeout_we_i    <= 1'b1;
    tap_timeout_wdata_i <= value;
    @(posedge clk_i);
    tap_timeout_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n_items, input int ins_pct, input int del_pct);
    int         target;
    int         pick;
    int         reps;
    logic [3:0] k;
    target = live_items + n_items;
    while (live_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) begin
        // one word of taps on a single key
        k    = 4'($urandom_range(0, 9));
        reps = $urandom_range(1, 7);
        for (int i = 0; i < reps; i++) begin
          send_plain(OP_KEY, k, rand_idx());
          if ($urandom_range(0, 5) == 0) begin
            send_plain(OP_TICK, rand_key(), rand_idx());
          end
        end
      end else if (pick < ins_pct + del_pct) begin
        reps = $urandom_range(1, 4);
        for (int i = 0; i < reps; i++) begin
          send_plain(OP_KEY, KEY_BACK, rand_idx());
        end
      end else begin
        case ($urandom_range(0, 9))
          0: send_plain(OP_KEY, KEY_MODE, rand_idx());
          1, 2: begin
            reps = $urandom_range(1, 4);
            k    = $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT;
            for (int i = 0; i < reps; i++) begin
              send_plain(OP_KEY, k, rand_idx());
            end
          end
          3, 4: begin
            reps = $urandom_range(1, 10);
            for (int i = 0; i < reps; i++) begin
              send_plain(OP_TICK, rand_key(), rand_idx());
            end
          end
          5, 6, 7: begin
            reps = $urandom_range(1, 4);
            for (int i = 0; i < reps; i++) begin
              if ($urandom_range(0, 1)) begin
                send_plain(OP_READ, rand_key(), rand_idx());
              end else begin
                send_plain(OP_READ, rand_key(), 6'($urandom_range(0, 15)));
              end
            end
          end
          8: send_plain(op_e'(2'($urandom_range(0, 3))), rand_key(), rand_idx());
          default: begin
            if ($urandom_range(0, 1)) begin
              send_plain(OP_NOP, rand_key(), rand_idx());
            end else begin
              send_plain(OP_KEY, $urandom_range(0, 1) ? KEY_SPARE_LO : KEY_SPARE_HI, rand_idx());
            end
          end
        endcase
      end
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    request_t dir_tbl [$];

    // empty editor, ends and ignored codes
    dir_tbl.push_back(mk_t(OP_READ, 4'd0, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_READ, 4'd15, 6'd63, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_TICK, 4'd0, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_KEY, KEY_BACK, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_KEY, KEY_LEFT, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_KEY, KEY_RIGHT, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_KEY, KEY_SPARE_LO, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_KEY, KEY_SPARE_HI, 6'd0, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    dir_tbl.push_back(mk_t(OP_NOP, 4'd15, 6'd63, 8'h00, 7'd0, 7'd0, MODE_LOWER, 1'b0));
    // candidate, repeat tap, commit by another key, tap wrap
    dir_tbl.push_back(mk_t(OP_KEY, 4'd2, 6'd0, 8'h00, 7'd0, 7'd1, MODE_LOWER, 1'b1));
    dir_tbl.push_back(mk(OP_KEY, 4'd2, 6'd0));
    dir_tbl.push_back(mk_t(OP_READ, 4'd0, 6'd0, 8'h62, 7'd0, 7'd1, MODE_LOWER, 1'b1));
    dir_tbl.push_back(mk(OP_KEY, 4'd9, 6'd0));
    for (int i = 0; i < 5; i++) begin
      dir_tbl.push_back(mk(OP_KEY, 4'd9, 6'd0));
    end
    dir_tbl.push_back(mk(OP_READ, 4'd0, 6'd1));
    // backspace on a candidate, mode cycling, numeric entry, plain delete
    dir_tbl.push_back(mk(OP_KEY, KEY_BACK, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, KEY_MODE, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, 4'd0, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, KEY_MODE, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, 4'd5, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, KEY_LEFT, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, KEY_BACK, 6'd0));
    dir_tbl.push_back(mk(OP_KEY, KEY_MODE, 6'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i]);
    end

    // long timeout: the candidate is only committed by the last tick
    write_timeout(16'd64);
    steady = 1'b1;
    send_plain(OP_KEY, 4'd3, rand_idx());
    for (int i = 0; i < 64; i++) begin
      send_plain(OP_TICK, rand_key(), rand_idx());
    end
    steady = 1'b0;

    write_timeout(16'd1);
    run_random(250, 45, 10);
    write_timeout(16'd0);
    run_random(150, 45, 10);
    write_timeout(16'($urandom_range(2, 6)));
    run_random(300, 70, 5);
    write_timeout(TAP_TIMEOUT_RST);
    run_random(200, 40, 15);
    write_timeout(16'($urandom_range(3, 20)));
    run_random(300, 30, 30);

    start_i <= 1'b0;
    wait_drained();
    repeat (MAX_LEN + 8) @(posedge clk_i);
    if (mismatches == 0 && editor_view_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mtte_pkg.sv
design/mtte_text_mem.sv
design/mtte_ctrl.sv
design/multi_tap_text_entry_unit.sv
tb/sv/tb_multi_tap_text_entry_unit.sv
